/* src/ctsrv_pkg.sv */
// ----------------------------------------------------------------------------
// ctsrv_pkg
// Shared types and constants for the channel threshold servo.
// ----------------------------------------------------------------------------
`default_nettype none

package ctsrv_pkg;

    // Field widths
    localparam int unsigned CMD_W     = 2;
    localparam int unsigned CHAN_W    = 7;
    localparam int unsigned COUNT_W   = 16;
    localparam int unsigned STEP_W    = 14;
    localparam int unsigned LEVEL_W   = 15;
    localparam int unsigned ACTION_W  = 2;
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned CFG_DAT_W = 16;

    // Stream word widths, padded to whole bytes
    localparam int unsigned S_TDATA_W = 40;
    localparam int unsigned M_TDATA_W = 24;

    // Largest table the channel field can address
    localparam int unsigned TABLE_DEPTH_MAX = 1 << CHAN_W;

    // Default geometry
    localparam int unsigned BOARDS_DEF             = 16;
    localparam int unsigned CHANNELS_PER_BOARD_DEF = 8;

    // Highest representable level
    localparam logic [LEVEL_W-1:0] LEVEL_CEIL = '1;

    // Register reset values
    localparam logic [LEVEL_W-1:0] LEVEL_MIN_RST = 15'd2;
    localparam logic [LEVEL_W-1:0] LEVEL_MAX_RST = 15'd8191;
    localparam logic [COUNT_W-1:0] RATE_LOW_RST  = 16'd4;
    localparam logic [COUNT_W-1:0] RATE_HIGH_RST = 16'd8;

    typedef enum logic [CMD_W-1:0] {
        CMD_PRESET   = 2'd0,
        CMD_ADJUST   = 2'd1,
        CMD_ADJ_UP   = 2'd2,
        CMD_RESERVED = 2'd3
    } t_cmd;

    typedef enum logic [ACTION_W-1:0] {
        ACT_HELD    = 2'd0,
        ACT_RAISED  = 2'd1,
        ACT_LOWERED = 2'd2,
        ACT_PRESET  = 2'd3
    } t_action;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_LEVEL_MIN = 2'd0,
        REG_LEVEL_MAX = 2'd1,
        REG_RATE_LOW  = 2'd2,
        REG_RATE_HIGH = 2'd3
    } t_reg_idx;

endpackage : ctsrv_pkg

`default_nettype wire

/* src/channel_threshold_servo.sv */
// ----------------------------------------------------------------------------
// channel_threshold_servo
// Per-channel trigger threshold servo over a single-port threshold table.
// ----------------------------------------------------------------------------
// Each input word names a channel and a command; the block reads that
// channel's threshold from an on-chip table, moves it by the step according
// to the gated trigger count and the discriminator bit, writes it back and
// returns one result word with the new level and what happened to it. Each
// item is read from the table (synchronous memory) on accept, then computed
// and written back; no new word is taken until the write back, which waits
// while an untaken result sits in the output register. A finished result
// sits in the output register while the next word is accepted and read.
// Table entries are not cleared by reset: preset a channel before adjusting
// it. Channels at or above BOARDS * CHANNELS_PER_BOARD leave the table alone
// and report level zero, held. The user must write configuration registers
// through the cfg channel while the block is idle; the block does not enforce it.
// ----------------------------------------------------------------------------
`default_nettype none

module channel_threshold_servo #(
    parameter int unsigned BOARDS             = ctsrv_pkg::BOARDS_DEF,
    parameter int unsigned CHANNELS_PER_BOARD = ctsrv_pkg::CHANNELS_PER_BOARD_DEF
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    // Configuration write channel
    input  wire logic                               i_cfg_valid,
    output logic                                    o_cfg_ready,
    input  wire logic [ctsrv_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [ctsrv_pkg::CFG_DAT_W-1:0]    i_cfg_data,
    // Input stream
    input  wire logic                               s_axis_tvalid,
    output logic                                    s_axis_tready,
    // tdata: channel[6:0], trigger_count[22:7], disc_above[23], step[37:24], zero[39:38]
    input  wire logic [ctsrv_pkg::S_TDATA_W-1:0]    s_axis_tdata,
    // tuser: cmd[1:0]
    input  wire logic [ctsrv_pkg::CMD_W-1:0]        s_axis_tuser,
    // Output stream
    output logic                                    m_axis_tvalid,
    input  wire logic                               m_axis_tready,
    // tdata: out_channel[6:0], new_level[21:7], action[23:22]
    output logic [ctsrv_pkg::M_TDATA_W-1:0]         m_axis_tdata
);

    import ctsrv_pkg::*;

    localparam int unsigned LIMIT = BOARDS * CHANNELS_PER_BOARD;
    localparam int unsigned DEPTH = (LIMIT < TABLE_DEPTH_MAX) ? LIMIT : TABLE_DEPTH_MAX;
    localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [CHAN_W:0] LIMIT_CODE = (CHAN_W+1)'(DEPTH);

    // Configuration registers
    logic [LEVEL_W-1:0] r_level_min;
    logic [LEVEL_W-1:0] r_level_max;
    logic [COUNT_W-1:0] r_rate_low;
    logic [COUNT_W-1:0] r_rate_high;

    // Item held during the compute cycle
    logic               r_busy;
    t_cmd               r_cmd;
    logic [CHAN_W-1:0]  r_chan;
    logic [COUNT_W-1:0] r_count;
    logic               r_disc;
    logic [STEP_W-1:0]  r_step;

    // Threshold table
    logic [LEVEL_W-1:0] r_table [DEPTH];
    logic [LEVEL_W-1:0] r_rd_data;

    // Output register
    logic                r_out_valid;
    logic [CHAN_W-1:0]   r_out_chan;
    logic [LEVEL_W-1:0]  r_out_level;
    t_action             r_out_action;

    logic               s_fire;
    logic               compute;
    logic               in_range;
    logic [LEVEL_W-1:0] n_level;
    t_action            n_action;
    logic [LEVEL_W:0]   sum;
    logic [LEVEL_W:0]   floor_sum;
    logic [LEVEL_W-1:0] sat_sum;
    logic [LEVEL_W-1:0] raise_many;
    logic [LEVEL_W-1:0] lower_lev;

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = ~r_busy;
    assign s_fire        = s_axis_tvalid & s_axis_tready;
    assign compute       = r_busy & (~r_out_valid | m_axis_tready);

    // Write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level_min <= LEVEL_MIN_RST;
            r_level_max <= LEVEL_MAX_RST;
            r_rate_low  <= RATE_LOW_RST;
            r_rate_high <= RATE_HIGH_RST;
        end else if (i_cfg_valid) begin
            unique case (t_reg_idx'(i_cfg_index))
                REG_LEVEL_MIN: r_level_min <= i_cfg_data[LEVEL_W-1:0];
                REG_LEVEL_MAX: r_level_max <= i_cfg_data[LEVEL_W-1:0];
                REG_RATE_LOW:  r_rate_low  <= i_cfg_data;
                REG_RATE_HIGH: r_rate_high <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Track the item in flight
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (s_fire) begin
            r_busy <= 1'b1;
        end else if (compute) begin
            r_busy <= 1'b0;
        end
    end

    // Capture the input word
    always_ff @(posedge i_clk) begin
        if (s_fire) begin
            r_cmd   <= t_cmd'(s_axis_tuser);
            r_chan  <= s_axis_tdata[6:0];
            r_count <= s_axis_tdata[22:7];
            r_disc  <= s_axis_tdata[23];
            r_step  <= s_axis_tdata[37:24];
        end
    end

    // Read on accept, write back on compute
    always_ff @(posedge i_clk) begin
        if (s_fire) begin
            r_rd_data <= r_table[s_axis_tdata[AW-1:0]];
        end
        if (compute && in_range) begin
            r_table[r_chan[AW-1:0]] <= n_level;
        end
    end

    // Next level
    assign in_range  = {1'b0, r_chan} < LIMIT_CODE;
    assign sum       = {1'b0, r_rd_data} + (LEVEL_W+1)'(r_step);
    assign floor_sum = {1'b0, r_level_min} + (LEVEL_W+1)'(r_step);
    assign sat_sum   = sum[LEVEL_W] ? LEVEL_CEIL : sum[LEVEL_W-1:0];
    assign raise_many = (sum > {1'b0, r_level_max}) ? r_level_max : sum[LEVEL_W-1:0];
    assign lower_lev = ({1'b0, r_rd_data} >= floor_sum) ?
                       (r_rd_data - LEVEL_W'(r_step)) : r_level_min;

    always_comb begin
        n_level = r_rd_data;
        unique case (r_cmd) inside
            CMD_PRESET: n_level = r_level_max;
            CMD_ADJUST, CMD_ADJ_UP: begin
                if (r_count > r_rate_high) begin
                    n_level = raise_many;
                end else if (r_count < r_rate_low) begin
                    if (r_disc) begin
                        n_level = sat_sum;
                        if (r_cmd == CMD_ADJUST && sat_sum < r_level_min) begin
                            n_level = r_level_min;
                        end
                    end else if (r_cmd == CMD_ADJUST) begin
                        n_level = lower_lev;
                    end
                end
            end
            default: n_level = r_rd_data;
        endcase
    end

    // Classify the change
    always_comb begin
        if (!in_range) begin
            n_action = ACT_HELD;
        end else if (r_cmd == CMD_PRESET) begin
            n_action = ACT_PRESET;
        end else if (n_level > r_rd_data) begin
            n_action = ACT_RAISED;
        end else if (n_level < r_rd_data) begin
            n_action = ACT_LOWERED;
        end else begin
            n_action = ACT_HELD;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (compute) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (compute) begin
            r_out_chan   <= r_chan;
            r_out_level  <= in_range ? n_level : '0;
            r_out_action <= n_action;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out_action, r_out_level, r_out_chan};

`ifndef SYNTHESIS
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_fire |=> r_busy)
        else $error("accepted word did not start a table access");

    a_result_from_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_busy))
        else $error("result appeared without an item in flight");

    a_preset_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_action == ACT_PRESET) |-> (r_out_level == r_level_max))
        else $error("preset result differs from level_max");

    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && !compute) |=> r_busy)
        else $error("item dropped before write back");
`endif

endmodule : channel_threshold_servo

`default_nettype wire
